>>> rtl/core/miller_rabin_prime_test_64_assert.svh
// Assertion macros used by the checker file.
`ifndef MILLER_RABIN_PRIME_TEST_64_ASSERT_SVH
`define MILLER_RABIN_PRIME_TEST_64_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define MRPT_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Implication whose consequent is checked in the cycle after the antecedent.
`define MRPT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

>>> rtl/core/mrpt_pkg.sv
// ----------------------------------------------------------------------------
// mrpt_pkg
// Shared constants and types of the Miller-Rabin primality tester.
// ----------------------------------------------------------------------------
package mrpt_pkg;

   localparam int unsigned WordWidth = 64;
   localparam int unsigned BaseCount = 12;
   localparam int unsigned BaseIdxWidth = 4;
   localparam int unsigned BitIdxWidth = 6;

   typedef logic [WordWidth-1:0] word_type;

   // Modular multiplier command and status.
   typedef struct packed {
      logic     start;
      word_type x;
      word_type y;
      word_type m;
   } mul_cmd_type;

   typedef struct packed {
      logic     done;
      word_type prod;
   } mul_rsp_type;

   function automatic word_type witness_base(input logic [BaseIdxWidth-1:0] idx);
      word_type b;
      b = '0;
      unique case (idx)
         4'd0:    b[5:0] = 6'd2;
         4'd1:    b[5:0] = 6'd3;
         4'd2:    b[5:0] = 6'd5;
         4'd3:    b[5:0] = 6'd7;
         4'd4:    b[5:0] = 6'd11;
         4'd5:    b[5:0] = 6'd13;
         4'd6:    b[5:0] = 6'd17;
         4'd7:    b[5:0] = 6'd19;
         4'd8:    b[5:0] = 6'd23;
         4'd9:    b[5:0] = 6'd29;
         4'd10:   b[5:0] = 6'd31;
         4'd11:   b[5:0] = 6'd37;
         default: b[5:0] = 6'd37;
      endcase
      return b;
   endfunction

endpackage

>>> rtl/core/mrpt_modmul.sv
// ----------------------------------------------------------------------------
// mrpt_modmul
// Bit-serial modular multiplier: one bit of y per cycle.
// ----------------------------------------------------------------------------
module mrpt_modmul
   import mrpt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mul_cmd_type cmd,
   output mul_rsp_type rsp
);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [BitIdxWidth-1:0] bit_ff, bit_in;
   word_type               acc_ff, acc_in, x_ff, x_in, y_ff, y_in, m_ff, m_in;

   // Doubling then conditional addition, each reduced by one subtraction.
   function automatic word_type add_mod(input word_type a, input word_type b,
                                        input word_type m);
      logic [WordWidth:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, m}) s = s - {1'b0, m};
      return s[WordWidth-1:0];
   endfunction

   always_comb begin
      word_type dbl;
      busy_in = busy_ff;
      done_in = 1'b0;
      bit_in  = bit_ff;
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      m_in    = m_ff;
      dbl     = add_mod(acc_ff, acc_ff, m_ff);
      if (cmd.start) begin
         busy_in = 1'b1;
         bit_in  = '1;
         acc_in  = '0;
         x_in    = cmd.x;
         y_in    = cmd.y;
         m_in    = cmd.m;
      end else if (busy_ff) begin
         acc_in = y_ff[WordWidth-1] ? add_mod(dbl, x_ff, m_ff) : dbl;
         y_in   = {y_ff[WordWidth-2:0], 1'b0};
         bit_in = bit_ff - 1'b1;
         if (bit_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      bit_ff <= bit_in;
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
      m_ff   <= m_in;
   end

   assign rsp.done = done_ff;
   assign rsp.prod = acc_ff;

endmodule

>>> rtl/core/miller_rabin_prime_test_64.sv
// ----------------------------------------------------------------------------
// miller_rabin_prime_test_64
// Deterministic Miller-Rabin primality test of a 64-bit unsigned value.
// ----------------------------------------------------------------------------
// The request channel carries one candidate per transaction; the response
// channel returns one transaction with the prime flag for each candidate.
// The block works on one candidate at a time: req_tready is high only while
// it is idle and no result is waiting. A shared bit-serial modular
// multiplier does all the arithmetic, and the sequencer waits for each
// product, so the time per candidate is set by the number of products:
// up to twelve bases, each needing one squaring per bit of d, one
// multiply per set bit of d and then up to s-1 squarings, which is at
// most about 127 products. The values 0 to 4 raise rsp_tvalid on the
// cycle after acceptance; an even candidate has s zero, so it is rejected
// by the first base, if any, whose power is neither 1 nor p-1. Stripping
// trailing zeros of p-1 takes one cycle per zero.
// A finished result is held in the response register until the receiver
// takes it; a stalled receiver simply holds the block in its done state.
// Synchronous reset returns the sequencer to idle and drops rsp_tvalid.
// There is no configuration port.
module miller_rabin_prime_test_64
   import mrpt_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [63:0] req_tdata,   // [63:0] candidate
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata     // [0] prime_flag, [7:1] zero
);

   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_STRIP  = 9'b000000010,
      ST_BASE   = 9'b000000100,
      ST_POWMUL = 9'b000001000,
      ST_POWSQ  = 9'b000010000,
      ST_CHECK  = 9'b000100000,
      ST_SQ     = 9'b001000000,
      ST_SQCHK  = 9'b010000000,
      ST_DONE   = 9'b100000000
   } state_type;

   state_type              state_ff, state_in;
   word_type               p_ff, p_in, d_ff, d_in, e_ff, e_in;
   word_type               r_ff, r_in, b_ff, b_in;
   logic [BitIdxWidth-1:0] s_ff, s_in, i_ff, i_in;
   logic [BaseIdxWidth-1:0] base_ff, base_in;
   logic                   flag_ff, flag_in;
   logic                   wait_ff, wait_in;
   mul_cmd_type            cmd;
   mul_rsp_type            rsp;
   word_type               pm1;

   mrpt_modmul u_mul (.clock(clock), .reset(reset), .cmd(cmd), .rsp(rsp));

   assign pm1 = p_ff - 64'd1;

   always_comb begin
      word_type a;
      state_in = state_ff;
      p_in = p_ff; d_in = d_ff; e_in = e_ff; r_in = r_ff; b_in = b_ff;
      s_in = s_ff; i_in = i_ff; base_in = base_ff; flag_in = flag_ff;
      wait_in = wait_ff;
      cmd = '0;
      cmd.m = p_ff;
      a = witness_base(base_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               p_in = req_tdata;
               d_in = req_tdata - 64'd1;
               s_in = '0;
               base_in = '0;
               if (req_tdata <= 64'd1 || req_tdata == 64'd4) begin
                  flag_in = 1'b0; state_in = ST_DONE;
               end else if (req_tdata <= 64'd3) begin
                  flag_in = 1'b1; state_in = ST_DONE;
               end else begin
                  state_in = ST_STRIP;
               end
            end
         end
         ST_STRIP: begin
            if (d_ff[0]) state_in = ST_BASE;
            else begin
               d_in = {1'b0, d_ff[WordWidth-1:1]};
               s_in = s_ff + 1'b1;
            end
         end
         ST_BASE: begin
            // Bases are below 64 here; p above four, so a mod p is a itself.
            if (base_ff == BaseIdxWidth'(BaseCount) || p_ff <= a) begin
               flag_in = 1'b1; state_in = ST_DONE;
            end else begin
               r_in = 64'd1; b_in = a; e_in = d_ff;
               wait_in = 1'b0;
               state_in = ST_POWMUL;
            end
         end
         ST_POWMUL: begin
            if (!wait_ff) begin
               if (e_ff == '0) state_in = ST_CHECK;
               else if (e_ff[0]) begin
                  cmd.start = 1'b1; cmd.x = r_ff; cmd.y = b_ff; wait_in = 1'b1;
               end else state_in = ST_POWSQ;
            end else if (rsp.done) begin
               r_in = rsp.prod; wait_in = 1'b0; state_in = ST_POWSQ;
            end
         end
         ST_POWSQ: begin
            if (!wait_ff) begin
               cmd.start = 1'b1; cmd.x = b_ff; cmd.y = b_ff; wait_in = 1'b1;
            end else if (rsp.done) begin
               b_in = rsp.prod; wait_in = 1'b0;
               e_in = {1'b0, e_ff[WordWidth-1:1]};
               state_in = ST_POWMUL;
            end
         end
         ST_CHECK: begin
            i_in = 6'd1;
            if (r_ff == 64'd1 || r_ff == pm1) begin
               base_in = base_ff + 1'b1; state_in = ST_BASE;
            end else if (s_ff <= 6'd1) begin
               flag_in = 1'b0; state_in = ST_DONE;
            end else state_in = ST_SQ;
         end
         ST_SQ: begin
            if (!wait_ff) begin
               cmd.start = 1'b1; cmd.x = r_ff; cmd.y = r_ff; wait_in = 1'b1;
            end else if (rsp.done) begin
               r_in = rsp.prod; wait_in = 1'b0; state_in = ST_SQCHK;
            end
         end
         ST_SQCHK: begin
            if (r_ff == pm1) begin
               base_in = base_ff + 1'b1; state_in = ST_BASE;
            end else if (r_ff == 64'd1 || i_ff + 1'b1 >= s_ff) begin
               flag_in = 1'b0; state_in = ST_DONE;
            end else begin
               i_in = i_ff + 1'b1; state_in = ST_SQ;
            end
         end
         ST_DONE: begin
            if (rsp_tready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         wait_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         wait_ff  <= wait_in;
      end
      p_ff <= p_in; d_ff <= d_in; e_ff <= e_in; r_ff <= r_in; b_ff <= b_in;
      s_ff <= s_in; i_ff <= i_in; base_ff <= base_in; flag_ff <= flag_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = (state_ff == ST_DONE);
   assign rsp_tdata  = {7'd0, flag_ff};

endmodule

>>> rtl/core/mrpt_checker.sv
// ----------------------------------------------------------------------------
// mrpt_checker
// Port-level checks of the primality tester, bound to the top level.
// ----------------------------------------------------------------------------
`include "miller_rabin_prime_test_64_assert.svh"

module mrpt_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_tvalid,
   input logic       req_tready,
   input logic [63:0] req_tdata,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata
);

   logic rsp_stall;
   logic small_comp;

   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign small_comp = req_tvalid && req_tready &&
                       (req_tdata == 64'd0 || req_tdata == 64'd1 || req_tdata == 64'd4);

   // One candidate in flight: never ready while a result is pending.
   `MRPT_ASSERT_IMPL(a_excl, clock, reset, rsp_tvalid, !req_tready)
   // A stalled result keeps its value.
   `MRPT_ASSERT_NEXT(a_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_tdata))
   // Padding bits stay zero.
   `MRPT_ASSERT_IMPL(a_pad, clock, reset, rsp_tvalid, rsp_tdata[7:1] == 7'd0)
   // Small composites answer as composite.
   `MRPT_ASSERT_NEXT(a_small, clock, reset, small_comp, rsp_tvalid && !rsp_tdata[0])

endmodule

bind miller_rabin_prime_test_64 mrpt_checker u_mrpt_checker (.*);

>>> tb/miller_rabin_prime_test_64_tb.sv
// ----------------------------------------------------------------------------
// miller_rabin_prime_test_64_tb
// Self-checking bench for the 64-bit Miller-Rabin primality tester.
// ----------------------------------------------------------------------------
// Candidates go in on the request channel, and a local primality predictor
// works out the flag that each one should give. A scoreboard keeps the
// expected flags in order and compares every response transaction with the
// oldest of them. Both sides insert random idle cycles, and once the
// receiver holds off for a long stretch so that the block stalls its input.
module miller_rabin_prime_test_64_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mrpt_pkg::*;

   localparam int unsigned RandomCount = 80;
   localparam longint unsigned CycleLimit = 64'd60_000_000;
   localparam int unsigned DrainCycles = 200;

   // Scoreboard: holds expected prime flags in request order.
   class prime_flag_board;
      bit flag_queue[$];
      int unsigned mismatch_count;
      int unsigned checked_count;
      int unsigned prime_count;

      function void note_candidate(bit flag);
         flag_queue.push_back(flag);
      endfunction

      task check_flag(logic [7:0] rsp_data);
         bit expected_flag;
         if (flag_queue.size() == 0) begin
            report_mismatch($sformatf("response 0x%02h with nothing outstanding", rsp_data));
         end else begin
            expected_flag = flag_queue.pop_front();
            checked_count++;
            if (expected_flag)
               prime_count++;
            if (rsp_data[0] !== expected_flag)
               report_mismatch($sformatf("prime_flag %b, expected %b", rsp_data[0],
                                         expected_flag));
            if (rsp_data[7:1] !== 7'd0)
               report_mismatch($sformatf("padding bits 0x%02h not zero", rsp_data[7:1]));
         end
      endtask

      task report_mismatch(string msg);
         mismatch_count++;
         $display("mismatch at %0t: %s", $realtime, msg);
      endtask
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [63:0] req_tdata;   // [63:0] candidate
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;   // [0] prime_flag, [7:1] zero

   prime_flag_board board;
   longint unsigned cycle_count;
   bit              stim_done;
   bit              hold_off;
   int unsigned     sent_count;

   miller_rabin_prime_test_64 dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // ---- Predictor --------------------------------------------------------
   // (x * y) mod m by shift-and-add, so no product ever exceeds 64 bits.
   function automatic logic [63:0] mul_mod(logic [63:0] x, logic [63:0] y, logic [63:0] m);
      logic [64:0] acc;
      acc = '0;
      for (int b = 63; b >= 0; b--) begin
         acc = acc + acc;
         if (acc >= {1'b0, m})
            acc = acc - {1'b0, m};
         if (y[b]) begin
            acc = acc + {1'b0, x};
            if (acc >= {1'b0, m})
               acc = acc - {1'b0, m};
         end
      end
      return acc[63:0];
   endfunction

   function automatic logic [63:0] pow_mod(logic [63:0] a, logic [63:0] e, logic [63:0] m);
      logic [63:0] r;
      logic [63:0] sq;
      r = 64'd1;
      sq = a % m;
      while (e != 0) begin
         if (e[0])
            r = mul_mod(r, sq, m);
         sq = mul_mod(sq, sq, m);
         e = e >> 1;
      end
      return r;
   endfunction

   function automatic bit predict_prime(logic [63:0] p);
      logic [63:0] d;
      logic [63:0] x;
      int unsigned twos;
      bit          passed;
      if (p <= 64'd1 || p == 64'd4)
         return 1'b0;
      if (p <= 64'd3)
         return 1'b1;
      d = p - 64'd1;
      twos = 0;
      while (!d[0]) begin
         d = d >> 1;
         twos++;
      end
      for (int i = 0; i < BaseCount; i++) begin
         if (p <= witness_base(i[BaseIdxWidth-1:0]))
            break;
         x = pow_mod(witness_base(i[BaseIdxWidth-1:0]), d, p);
         passed = (x == 64'd1) || (x == p - 64'd1);
         for (int k = 1; k < twos && !passed; k++) begin
            x = mul_mod(x, x, p);
            if (x == p - 64'd1)
               passed = 1'b1;
            else if (x == 64'd1)
               break;
         end
         if (!passed)
            return 1'b0;
      end
      return 1'b1;
   endfunction

   // ---- Request side -----------------------------------------------------
   // Offers one candidate after a random gap and waits for its handshake.
   // The valid line is only dropped when a gap follows, so back-to-back
   // offers keep it high.
   task automatic send_candidate(logic [63:0] cand);
      int unsigned gap;
      gap = $urandom_range(0, 12);
      if ($urandom_range(0, 3) == 0)
         gap = 0;
      if (gap > 0)
         req_tvalid <= 1'b0;
      repeat (gap) @(posedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= cand;
      do @(posedge clock); while (!req_tready);
      board.note_candidate(predict_prime(cand));
      sent_count++;
   endtask

   // Random 64-bit odd number of a chosen bit length; short lengths are
   // favoured because large candidates take longer to test.
   function automatic logic [63:0] random_odd();
      int unsigned len;
      logic [63:0] v;
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(33, 64) : $urandom_range(2, 32);
      v = {$urandom, $urandom};
      if (len < 64)
         v = v & ((64'd1 << len) - 64'd1);
      v[len-1] = 1'b1;
      v[0] = 1'b1;
      return v;
   endfunction

   initial begin
      logic [63:0] directed[$];
      logic [63:0] cand;
      int unsigned pick;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      reset      = 1'b1;
      stim_done  = 1'b0;
      sent_count = 0;
      board = new();
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Small values, bases at or above the candidate, strong pseudoprimes
      // to the first bases, large even values, the largest values and a few others.
      directed = '{64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd9, 64'd37, 64'd41,
                   64'd2047, 64'd1373653, 64'd25326001, 64'd3215031751,
                   64'd3825123056546413051, 64'hFFFF_FFFF_FFFF_FFFE,
                   64'hFFFF_FFFF_FFFF_FFC5, 64'hFFFF_FFFF_FFFF_FFFF,
                   64'h8000_0000_0000_0000, 64'd1000000007, 64'd561,
                   64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAB};
      foreach (directed[i])
         send_candidate(directed[i]);

      for (int n = 0; n < RandomCount; n++) begin
         pick = $urandom_range(0, 9);
         if (pick == 0)
            cand = {$urandom, $urandom};            // any value, even ones too
         else if (pick == 1)
            cand = 64'($urandom_range(0, 64));
         else if (pick < 4) begin
            // Product of two odd factors: a composite unless the low factor is one.
            cand = random_odd();
            cand = (cand & 64'hFFFF) * 64'($urandom_range(1, 4000) * 2 + 1);
         end else
            cand = random_odd();
         send_candidate(cand);
      end
      req_tvalid <= 1'b0;
      stim_done = 1'b1;
   end

   // ---- Response side ----------------------------------------------------
   // Long hold-off early in the run so the block stalls with a result held.
   initial begin
      hold_off = 1'b0;
      wait (sent_count == 3);
      hold_off = 1'b1;
      repeat (3000) @(posedge clock);
      hold_off = 1'b0;
   end

   initial begin
      int unsigned gap;
      rsp_tready = 1'b0;
      @(negedge reset);
      forever begin
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
         if (gap > 0 || hold_off)
            rsp_tready <= 1'b0;
         repeat (gap) @(posedge clock);
         while (hold_off) @(posedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         board.check_flag(rsp_tdata);
      end
   end

   // ---- End of run and watchdog ------------------------------------------
   initial begin
      wait (stim_done && board.flag_queue.size() == 0);
      repeat (DrainCycles) @(posedge clock);
      $display("Tested %0d candidates, %0d of them prime, with random gaps and a long stall.",
               board.checked_count, board.prime_count);
      if (board.mismatch_count == 0 && board.flag_queue.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

   initial begin
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (cycle_count >= CycleLimit) begin
            $display("Timeout after %0d cycles.", cycle_count);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

endmodule
